// ===== rtl/generational_handle_allocator_assert.svh =====
// assertion macros used by the checker file of the handle allocator
// expects signals named clk and rst_n in the scope of use
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// condition and consequence in the same cycle
`define GHA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gha_pkg.sv =====
// shared codes, field widths and defaults for the generational handle allocator
// no dependencies
package gha_pkg;

    localparam int IDX_PORT_W     = 10;
    localparam int GEN_W          = 22;
    localparam int THR_W          = 10;
    localparam int OP_W           = 2;
    localparam int ST_W           = 2;
    localparam int INDEX_WIDTH_DEF = 10;
    localparam logic [THR_W-1:0] THR_RESET = 10'd16;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_DEAD = 2'd2;

    typedef logic [GEN_W-1:0] gen_t;

endpackage

// ===== rtl/generational_handle_allocator.sv =====
// generational handle allocator, top level
// depends on gha_pkg and gha_ram

// Hands out handles made of a slot index and a generation. One request is
// in flight at a time: busy is high while a request works and start is taken
// only when busy is low. A result appears in the cycle after the request's
// last step, with done high for that single cycle; the receiver cannot stall
// it, and a new request may be started in that same cycle. Create of a fresh
// slot, a failed create, a destroy or query of an index never opened, and the
// unused opcode finish in the idle state. Destroy and query of an opened slot
// first read the generation table. Create that reuses a freed index reads the
// free queue, then the generation table. Both memories have registered read
// data and are read one after the other. No clearing pass runs after reset:
// generation entries are only read once their slot is opened, queue entries
// only once pushed. reuse_threshold is written through cfg_we / cfg_wdata;
// the user must write it only while idle; the block itself does not enforce it.
module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int INDEX_WIDTH = gha_pkg::INDEX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request side
    input  logic                           start,
    output logic                           busy,
    input  logic [gha_pkg::OP_W-1:0]       opcode,
    input  logic [gha_pkg::IDX_PORT_W-1:0] handle_index,
    input  logic [gha_pkg::GEN_W-1:0]      handle_generation,
    // configuration
    input  logic                           cfg_we,
    input  logic [gha_pkg::THR_W-1:0]      cfg_wdata,
    // result side
    output logic                           done,
    output logic [gha_pkg::IDX_PORT_W-1:0] out_index,
    output logic [gha_pkg::GEN_W-1:0]      out_generation,
    output logic                           alive,
    output logic [gha_pkg::ST_W-1:0]       status
);

    import gha_pkg::*;

    localparam int IW    = INDEX_WIDTH;
    localparam int SLOTS = 1 << IW;
    localparam int CNT_W = IW + 1;
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int EXT_W = IW + IDX_PORT_W;

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request
    localparam logic [1:0] S_QWAIT = 2'd1;  // free queue read in flight
    localparam logic [1:0] S_GWAIT = 2'd2;  // generation read in flight

    logic [1:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [IW-1:0]       idx_reg, idx_next;      // slot being worked on
    gen_t                hgen_reg, hgen_next;    // generation carried by request
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;  // queued free indices
    logic [CNT_W-1:0]    opened_reg, opened_next;
    logic [THR_W-1:0]    thr_reg;

    // result registers
    logic                done_reg, done_next;
    logic [IDX_PORT_W-1:0] oidx_reg, oidx_next;
    gen_t                ogen_reg, ogen_next;
    logic                alive_reg, alive_next;
    logic [ST_W-1:0]     status_reg, status_next;

    // memory ports
    logic                gen_we;
    logic [IW-1:0]       gen_waddr, gen_raddr;
    gen_t                gen_wdata, gen_rdata;
    logic                q_we;
    logic [IW-1:0]       q_rdata;

    // index conversions between the port width and the slot width
    logic [EXT_W-1:0]    req_idx_ext;
    logic [IW-1:0]       req_idx;
    logic [EXT_W-1:0]    res_idx_ext;
    logic [EXT_W-1:0]    new_idx_ext;

    logic                req_opened;
    logic                reuse_now;
    logic                gen_match;

    assign req_idx_ext = {{IW{1'b0}}, handle_index};
    assign req_idx     = req_idx_ext[IW-1:0];
    assign res_idx_ext = {{IDX_PORT_W{1'b0}}, idx_reg};
    assign new_idx_ext = {{IDX_PORT_W{1'b0}}, opened_reg[IW-1:0]};

    assign req_opened = {1'b0, req_idx} < opened_reg;
    // enough freed indices waiting to prefer reuse over a fresh slot
    assign reuse_now  = CMP_W'(count_reg) > CMP_W'(thr_reg);
    assign gen_match  = gen_rdata == hgen_reg;

    gha_ram #(
        .WIDTH (GEN_W),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (idx_reg),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        hgen_next   = hgen_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        opened_next = opened_reg;

        // results read as zero outside the done cycle
        done_next   = 1'b0;
        oidx_next   = '0;
        ogen_next   = '0;
        alive_next  = 1'b0;
        status_next = ST_OK;

        gen_we      = 1'b0;
        gen_waddr   = idx_reg;
        gen_wdata   = gen_rdata + 1'b1;   // wraps at the generation width
        gen_raddr   = req_idx;
        q_we        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = opcode;
                    idx_next  = req_idx;
                    hgen_next = handle_generation;
                    unique case (opcode)
                        OP_CREATE:
                        begin
                            priority if (reuse_now)
                            begin
                                // pop oldest freed index
                                head_next  = head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = S_QWAIT;
                            end
                            else if (!opened_reg[IW])
                            begin
                                // open a fresh slot at generation zero
                                gen_we      = 1'b1;
                                gen_waddr   = opened_reg[IW-1:0];
                                gen_wdata   = '0;
                                opened_next = opened_reg + 1'b1;
                                done_next   = 1'b1;
                                oidx_next   = new_idx_ext[IDX_PORT_W-1:0];
                                alive_next  = 1'b1;
                            end
                            else if (count_reg != '0)
                            begin
                                // out of fresh slots, fall back on reuse
                                head_next  = head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = S_QWAIT;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                        end
                        OP_DESTROY, OP_QUERY:
                        begin
                            if (req_opened)
                            begin
                                state_next = S_GWAIT;
                            end
                            else
                            begin
                                // slot never opened: handle cannot be alive
                                done_next   = 1'b1;
                                status_next = (opcode == OP_DESTROY) ? ST_DEAD : ST_OK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_QWAIT:
            begin
                idx_next   = q_rdata;
                gen_raddr  = q_rdata;
                state_next = S_GWAIT;
            end
            S_GWAIT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_CREATE:
                    begin
                        oidx_next  = res_idx_ext[IDX_PORT_W-1:0];
                        ogen_next  = gen_rdata;
                        alive_next = 1'b1;
                    end
                    OP_DESTROY:
                    begin
                        priority if (!gen_match)
                        begin
                            status_next = ST_DEAD;
                        end
                        else if (count_reg[IW])
                        begin
                            // queue already holds every slot
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            gen_we     = 1'b1;
                            q_we       = 1'b1;
                            tail_next  = tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                            alive_next = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        alive_next = gen_match;
                    end
                    default:
                    begin
                        alive_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            opened_reg <= '0;
            thr_reg    <= THR_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            opened_reg <= opened_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        hgen_reg   <= hgen_next;
        oidx_reg   <= oidx_next;
        ogen_reg   <= ogen_next;
        alive_reg  <= alive_next;
        status_reg <= status_next;
    end

    assign busy           = state_reg != S_IDLE;
    assign done           = done_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;
    assign alive          = alive_reg;
    assign status         = status_reg;

endmodule

// ===== rtl/gha_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gha_checker.sv =====
// port-level checks for the generational handle allocator, bound to the top
// depends on gha_pkg and generational_handle_allocator_assert.svh
`include "generational_handle_allocator_assert.svh"

module gha_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [gha_pkg::IDX_PORT_W-1:0] out_index,
    input logic [gha_pkg::GEN_W-1:0]      out_generation,
    input logic                           alive,
    input logic [gha_pkg::ST_W-1:0]       status
);

    import gha_pkg::*;

    // an accepted request either finishes at once or holds busy
    `GHA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "request lost after accept")

    // a result only follows an accepted request or work in progress
    `GHA_ASSERT_SAME(a_done_cause, done, $past(busy) || $past(start), "result without request")

    // no result shows while a request is still working
    `GHA_ASSERT_SAME(a_no_done_busy, busy, !done, "result during busy")

    // failed requests carry no handle
    `GHA_ASSERT_SAME(a_fail_clean, done && status != ST_OK,
        !alive && out_index == '0 && out_generation == '0, "failed result carries a handle")

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);
